/* design/quaternion_to_euler_angles_defines.svh */
// Assertion macros for the top-level design file.
`ifndef QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define QTE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define QTE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/qte_pkg.sv */
package qte_pkg;

    localparam int QUAT_BITS         = 16;
    localparam int ANGLE_BITS        = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // products and trig terms
    localparam int PROD_W    = 2 * QUAT_BITS;
    localparam int TERM_W    = 2 * QUAT_BITS;
    localparam int TERM_FRAC = 2 * (QUAT_BITS - 1) - 1;
    localparam int Q30_SHL   = 30 - TERM_FRAC;
    localparam int VEC_IN_W  = TERM_W + 1;

    // CORDIC datapath
    localparam int CW        = 36;
    localparam int ZW        = 34;
    localparam int ANG_SHIFT = 32 - ANGLE_BITS;
    localparam int ANG_EXT_W = ZW - ANG_SHIFT;

    // square root
    localparam int SQ_ITERS  = 31;
    localparam int SQ_W      = 2 * SQ_ITERS;
    localparam int SQ_ROOT_W = SQ_ITERS;
    localparam int SQRT_LAT  = SQ_ITERS + 2;

    localparam int TERMS_LAT = 2;

    typedef logic signed [TERM_W-1:0]   t_term;
    typedef logic signed [TERM_W:0]     t_sum;
    typedef logic signed [VEC_IN_W-1:0] t_vec;
    typedef logic signed [ZW-1:0]       t_zang;

    localparam longint TERM_LIM_L = longint'(1) <<< (2 * QUAT_BITS - 2);
    localparam longint TERM_ONE_L = longint'(1) <<< (2 * QUAT_BITS - 3);
    localparam t_sum   SUM_LIM    = t_sum'(TERM_LIM_L);
    localparam t_sum   SUM_ONE    = t_sum'(TERM_ONE_L);
    localparam t_term  TERM_ONE   = t_term'(TERM_ONE_L);

    typedef struct packed {
        logic signed [QUAT_BITS-1:0] quat_x;
        logic signed [QUAT_BITS-1:0] quat_y;
        logic signed [QUAT_BITS-1:0] quat_z;
        logic signed [QUAT_BITS-1:0] quat_w;
        logic                        sample_complete;
    } t_quat_in;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] roll_angle;
        logic signed [ANGLE_BITS-1:0] pitch_angle;
        logic signed [ANGLE_BITS-1:0] yaw_angle;
        logic                         angles_valid;
    } t_angles_out;

    typedef struct packed {
        t_term sr;
        t_term cr;
        t_term sy;
        t_term cy;
        t_term sp;
        logic  sat_pos;
        logic  sat_neg;
        logic  complete;
    } t_terms;

    function automatic t_term sat_term(input t_sum v);
        t_sum r;
        if (v > SUM_LIM) begin
            r = SUM_LIM;
        end else if (v < -SUM_LIM) begin
            r = -SUM_LIM;
        end else begin
            r = v;
        end
        return TERM_W'(r);
    endfunction

    function automatic t_vec to_q30(input t_term t);
        t_vec v;
        v = VEC_IN_W'(t);
        return v <<< Q30_SHL;
    endfunction

    // atan(2^-i), 2^32 per turn, rounded
    function automatic t_zang atan_entry(input int i);
        t_zang a;
        case (i)
            0:  a = ZW'(536870912);
            1:  a = ZW'(316933406);
            2:  a = ZW'(167458907);
            3:  a = ZW'(85004756);
            4:  a = ZW'(42667331);
            5:  a = ZW'(21354465);
            6:  a = ZW'(10679838);
            7:  a = ZW'(5340245);
            8:  a = ZW'(2670163);
            9:  a = ZW'(1335087);
            10: a = ZW'(667544);
            11: a = ZW'(333772);
            12: a = ZW'(166886);
            13: a = ZW'(83443);
            14: a = ZW'(41722);
            15: a = ZW'(20861);
            16: a = ZW'(10430);
            17: a = ZW'(5215);
            18: a = ZW'(2608);
            19: a = ZW'(1304);
            20: a = ZW'(652);
            21: a = ZW'(326);
            22: a = ZW'(163);
            23: a = ZW'(81);
            24: a = ZW'(41);
            25: a = ZW'(20);
            26: a = ZW'(10);
            27: a = ZW'(5);
            28: a = ZW'(3);
            29: a = ZW'(1);
            30: a = ZW'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

/* design/qte_terms.sv */
module qte_terms
    import qte_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_quat_in i_item,
    output logic     o_valid,
    output t_terms   o_terms
);

    logic signed [PROD_W-1:0] r_wx, r_yz, r_xx, r_yy, r_wz, r_xy, r_zz, r_wy, r_zx;
    logic   r_complete;
    logic   r_vld1;
    logic   r_vld2;
    t_terms r_terms;
    t_terms n_terms;
    t_term  rr_sat;
    t_term  yy_sat;

    // stage 1: exact products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else begin
            r_vld1 <= i_valid;
        end
        r_wx       <= PROD_W'(i_item.quat_w) * PROD_W'(i_item.quat_x);
        r_yz       <= PROD_W'(i_item.quat_y) * PROD_W'(i_item.quat_z);
        r_xx       <= PROD_W'(i_item.quat_x) * PROD_W'(i_item.quat_x);
        r_yy       <= PROD_W'(i_item.quat_y) * PROD_W'(i_item.quat_y);
        r_wz       <= PROD_W'(i_item.quat_w) * PROD_W'(i_item.quat_z);
        r_xy       <= PROD_W'(i_item.quat_x) * PROD_W'(i_item.quat_y);
        r_zz       <= PROD_W'(i_item.quat_z) * PROD_W'(i_item.quat_z);
        r_wy       <= PROD_W'(i_item.quat_w) * PROD_W'(i_item.quat_y);
        r_zx       <= PROD_W'(i_item.quat_z) * PROD_W'(i_item.quat_x);
        r_complete <= i_item.sample_complete;
    end

    // stage 2: sums, saturation, pitch limit flags
    always_comb begin
        rr_sat = sat_term(t_sum'(r_xx) + t_sum'(r_yy));
        yy_sat = sat_term(t_sum'(r_yy) + t_sum'(r_zz));
        n_terms.sr       = sat_term(t_sum'(r_wx) + t_sum'(r_yz));
        n_terms.cr       = sat_term(SUM_ONE - t_sum'(rr_sat));
        n_terms.sy       = sat_term(t_sum'(r_wz) + t_sum'(r_xy));
        n_terms.cy       = sat_term(SUM_ONE - t_sum'(yy_sat));
        n_terms.sp       = sat_term(t_sum'(r_wy) - t_sum'(r_zx));
        n_terms.sat_pos  = n_terms.sp >= TERM_ONE;
        n_terms.sat_neg  = n_terms.sp <= -TERM_ONE;
        n_terms.complete = r_complete;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
        end else begin
            r_vld2 <= r_vld1;
        end
        r_terms <= n_terms;
    end

    assign o_valid = r_vld2;
    assign o_terms = r_terms;

endmodule

/* design/qte_isqrt.sv */
module qte_isqrt
    import qte_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_vec                 i_s,
    output logic                 o_valid,
    output logic [SQ_ROOT_W-1:0] o_root
);

    localparam logic [SQ_W-1:0] FULL = SQ_W'(1) << (2 * (SQ_ITERS - 1));

    logic [VEC_IN_W-1:0] mag;
    logic [SQ_W+1:0]     r_sq;
    logic                r_vld_sq;
    logic [SQ_W-1:0]     r_v   [0:SQ_ITERS];
    logic [SQ_W-1:0]     r_r   [0:SQ_ITERS];
    logic                r_vld [0:SQ_ITERS];

    assign mag = i_s[VEC_IN_W-1] ? VEC_IN_W'(-i_s) : VEC_IN_W'(i_s);

    // square the sine, then form the remainder 1 - s^2 floored at zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_sq <= 1'b0;
            r_vld[0] <= 1'b0;
        end else begin
            r_vld_sq <= i_valid;
            r_vld[0] <= r_vld_sq;
        end
        r_sq   <= (SQ_W + 2)'(mag[VEC_IN_W-2:0]) * (SQ_W + 2)'(mag[VEC_IN_W-2:0]);
        r_v[0] <= (r_sq >= (SQ_W + 2)'(FULL)) ? '0 : SQ_W'((SQ_W + 2)'(FULL) - r_sq);
        r_r[0] <= '0;
    end

    // one result bit per stage
    for (genvar k = 0; k < SQ_ITERS; k++) begin : g_iter
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_ITERS - 1 - k));
        logic [SQ_W-1:0] trial;
        assign trial = r_r[k] + BIT;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            if (r_v[k] >= trial) begin
                r_v[k+1] <= r_v[k] - trial;
                r_r[k+1] <= (r_r[k] >> 1) + BIT;
            end else begin
                r_v[k+1] <= r_v[k];
                r_r[k+1] <= r_r[k] >> 1;
            end
        end
    end

    assign o_valid = r_vld[SQ_ITERS];
    assign o_root  = r_r[SQ_ITERS][SQ_ROOT_W-1:0];

endmodule

/* design/qte_cordic.sv */
module qte_cordic
    import qte_pkg::*;
#(
    parameter int STAGES = CORDIC_STAGES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  t_vec                        i_y,
    input  t_vec                        i_x,
    output logic                        o_valid,
    output logic signed [ANG_EXT_W-1:0] o_angle
);

    localparam t_zang Z_QUARTER = t_zang'(longint'(1) <<< 30);
    localparam t_zang Z_HALF    = (ANG_SHIFT > 0) ? t_zang'(longint'(1) <<< (ANG_SHIFT - 1))
                                                  : '0;

    logic signed [CW-1:0] xe, ye;
    logic signed [CW-1:0] r_x    [0:STAGES];
    logic signed [CW-1:0] r_y    [0:STAGES];
    t_zang                r_z    [0:STAGES];
    logic                 r_zero [0:STAGES];
    logic                 r_vld  [0:STAGES];
    logic                 r_vld_out;
    logic signed [ANG_EXT_W-1:0] r_angle;
    t_zang                z_round;

    assign xe = CW'(i_x);
    assign ye = CW'(i_y);

    // fold the left half plane onto the right
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_zero[0] <= (i_x == '0) && (i_y == '0);
        if (xe < 0) begin
            if (ye >= 0) begin
                r_x[0] <= ye;
                r_y[0] <= -xe;
                r_z[0] <= Z_QUARTER;
            end else begin
                r_x[0] <= -ye;
                r_y[0] <= xe;
                r_z[0] <= -Z_QUARTER;
            end
        end else begin
            r_x[0] <= xe;
            r_y[0] <= ye;
            r_z[0] <= '0;
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic signed [CW-1:0] dx, dy;
        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else begin
                r_vld[i+1] <= r_vld[i];
            end
            r_zero[i+1] <= r_zero[i];
            if (r_y[i] < 0) begin
                r_x[i+1] <= r_x[i] - dx;
                r_y[i+1] <= r_y[i] + dy;
                r_z[i+1] <= r_z[i] - atan_entry(i);
            end else begin
                r_x[i+1] <= r_x[i] + dx;
                r_y[i+1] <= r_y[i] - dy;
                r_z[i+1] <= r_z[i] + atan_entry(i);
            end
        end
    end

    // round half up to the output angle scale
    assign z_round = (r_z[STAGES] + Z_HALF) >>> ANG_SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_out <= 1'b0;
        end else begin
            r_vld_out <= r_vld[STAGES];
        end
        r_angle <= r_zero[STAGES] ? '0 : z_round[ANG_EXT_W-1:0];
    end

    assign o_valid = r_vld_out;
    assign o_angle = r_angle;

endmodule

/* design/quaternion_to_euler_angles.sv */
// Channel   Ports                     Handshake
// -------   -----------------------   ------------------------------------------
// input     i_item (t_quat_in)        beat taken on an edge with start && !busy
// result    o_result (t_angles_out)   beat shown for one cycle with o_done high
//
// A beat passes through the products and terms, the bit-per-stage square root
// that feeds pitch, the three parallel CORDIC pipelines and the output register.
// A new beat is taken every cycle; busy stays low.
// Reset (synchronous, active low) clears every valid bit; data registers are not reset.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module quaternion_to_euler_angles
    import qte_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_quat_in    i_item,
    output logic        o_done,
    output t_angles_out o_result
);

    localparam int CORDIC_LAT = CORDIC_STAGES + 2;
    localparam logic signed [ANG_EXT_W-1:0] HP = ANG_EXT_W'(1) <<< (ANGLE_BITS - 2);

    // operands held beside the square root
    typedef struct packed {
        t_vec ry;
        t_vec rx;
        t_vec yy;
        t_vec yx;
        t_vec s;
        logic sat_pos;
        logic sat_neg;
        logic complete;
    } t_side;

    // flags held beside the CORDICs
    typedef struct packed {
        logic sat_pos;
        logic sat_neg;
        logic complete;
    } t_flags;

    logic   accept;
    logic   terms_vld;
    t_terms terms;
    t_side  side_in;
    t_side  r_side [0:SQRT_LAT-1];
    t_side  side_out;
    logic   sq_vld;
    logic [SQ_ROOT_W-1:0] sq_root;
    t_vec   pitch_x;
    logic   cor_vld;
    logic   yaw_vld;
    logic   pitch_vld;
    logic signed [ANG_EXT_W-1:0] roll_ext, pitch_ext, yaw_ext;
    t_flags flags_in;
    t_flags r_flags [0:CORDIC_LAT-1];
    t_flags flags_out;
    logic signed [ANG_EXT_W-1:0] pitch_lim;
    logic        r_done;
    t_angles_out r_result;
    t_angles_out n_result;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    qte_terms u_terms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_item  (i_item),
        .o_valid (terms_vld),
        .o_terms (terms)
    );

    // scale the terms to Q30 vectors
    always_comb begin
        side_in.ry       = to_q30(terms.sr);
        side_in.rx       = to_q30(terms.cr);
        side_in.yy       = to_q30(terms.sy);
        side_in.yx       = to_q30(terms.cy);
        side_in.s        = to_q30(terms.sp);
        side_in.sat_pos  = terms.sat_pos;
        side_in.sat_neg  = terms.sat_neg;
        side_in.complete = terms.complete;
    end

    qte_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (terms_vld),
        .i_s     (side_in.s),
        .o_valid (sq_vld),
        .o_root  (sq_root)
    );

    // advance the operands in step with the square root
    always_ff @(posedge i_clk) begin
        r_side[0] <= side_in;
        for (int k = 1; k < SQRT_LAT; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end
    assign side_out = r_side[SQRT_LAT-1];
    assign pitch_x  = VEC_IN_W'(sq_root);

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_vld),
        .i_y     (side_out.ry),
        .i_x     (side_out.rx),
        .o_valid (cor_vld),
        .o_angle (roll_ext)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_vld),
        .i_y     (side_out.yy),
        .i_x     (side_out.yx),
        .o_valid (yaw_vld),
        .o_angle (yaw_ext)
    );

    // asin(s) as atan2(s, sqrt(1 - s^2))
    qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_vld),
        .i_y     (side_out.s),
        .i_x     (pitch_x),
        .o_valid (pitch_vld),
        .o_angle (pitch_ext)
    );

    assign flags_in.sat_pos  = side_out.sat_pos;
    assign flags_in.sat_neg  = side_out.sat_neg;
    assign flags_in.complete = side_out.complete;

    always_ff @(posedge i_clk) begin
        r_flags[0] <= flags_in;
        for (int k = 1; k < CORDIC_LAT; k++) begin
            r_flags[k] <= r_flags[k-1];
        end
    end
    assign flags_out = r_flags[CORDIC_LAT-1];

    // pin pitch to half pi at the limits, clamp it otherwise
    always_comb begin
        if (flags_out.sat_pos) begin
            pitch_lim = HP;
        end else if (flags_out.sat_neg) begin
            pitch_lim = -HP;
        end else if (pitch_ext > HP) begin
            pitch_lim = HP;
        end else if (pitch_ext < -HP) begin
            pitch_lim = -HP;
        end else begin
            pitch_lim = pitch_ext;
        end
    end

    // drop the angles of an incomplete sample
    always_comb begin
        if (flags_out.complete) begin
            n_result.roll_angle   = roll_ext[ANGLE_BITS-1:0];
            n_result.pitch_angle  = pitch_lim[ANGLE_BITS-1:0];
            n_result.yaw_angle    = yaw_ext[ANGLE_BITS-1:0];
            n_result.angles_valid = 1'b1;
        end else begin
            n_result = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= cor_vld;
        end
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

`include "quaternion_to_euler_angles_defines.svh"

    `QTE_ASSERT_IMP(a_pitch_range, o_done,
        (o_result.pitch_angle <= ANGLE_BITS'(HP)) && (o_result.pitch_angle >= -ANGLE_BITS'(HP)),
        "pitch beyond half pi")
    `QTE_ASSERT_IMP(a_incomplete_zero, o_done && !o_result.angles_valid,
        (o_result.roll_angle == '0) && (o_result.pitch_angle == '0) && (o_result.yaw_angle == '0),
        "incomplete sample gave nonzero angles")
    `QTE_ASSERT_NXT(a_cordic_to_done, cor_vld, o_done, "CORDIC beat lost before output")
    `QTE_ASSERT_IMP(a_lanes_in_step, 1'b1, (yaw_vld == cor_vld) && (pitch_vld == cor_vld),
        "CORDIC lanes out of step")

endmodule
